// ----- design/hvp_pkg.sv -----
// Shared types, codes and neighbour offset tables for the honeycomb vacancy placer.
package hvp_pkg;

    localparam int CRD_IN_W = 6;   // width of the cell_x and cell_y fields
    localparam int CFG_W    = 7;   // width of a side register write
    localparam int BOND_W   = 14;  // width of a bond index
    localparam int MARK_W   = 2;
    localparam int STEP_W   = 4;   // counts the ten site writes of a placement
    localparam int BSTEP_W  = 2;   // counts the three bond results

    localparam logic [CFG_W-1:0]   SIDE_RST  = 7'd64;
    localparam logic [STEP_W-1:0]  SITE_LAST = 4'd9;
    localparam logic [BSTEP_W-1:0] BOND_LAST = 2'd2;

    localparam logic [MARK_W-1:0] MARK_FREE = 2'd0;
    localparam logic [MARK_W-1:0] MARK_VAC  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_EXCL = 2'd2;

    typedef enum logic [1:0] {
        STATUS_PLACED  = 2'd0,
        STATUS_TAKEN   = 2'd1,
        STATUS_RANGE   = 2'd2,
        STATUS_CLEARED = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        REG_CELLS_ACROSS = 1'b0,
        REG_CELLS_DOWN   = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        OFS_ZERO = 2'd0,
        OFS_INC  = 2'd1,
        OFS_DEC  = 2'd2
    } t_ofs;

    // Offset of one visited site from the requested cell, with the sublattice flip.
    typedef struct packed {
        t_ofs dx;
        t_ofs dy;
        logic flip;
    } t_step;

    function automatic t_ofs ofs_neg(input t_ofs o);
        t_ofs r;
        case (o)
            OFS_INC: r = OFS_DEC;
            OFS_DEC: r = OFS_INC;
            default: r = OFS_ZERO;
        endcase
        return r;
    endfunction

    // Sites written for a placement, in write order: the vacancy, then each
    // neighbour followed by its two further sites. Listed for an A vacancy;
    // a B vacancy visits the mirror image.
    function automatic t_step site_step(input logic [STEP_W-1:0] k, input logic sub);
        t_step s;
        case (k)
            4'd0:    s = '{OFS_ZERO, OFS_ZERO, 1'b0};
            4'd1:    s = '{OFS_ZERO, OFS_ZERO, 1'b1};
            4'd2:    s = '{OFS_ZERO, OFS_INC,  1'b0};
            4'd3:    s = '{OFS_INC,  OFS_INC,  1'b0};
            4'd4:    s = '{OFS_ZERO, OFS_DEC,  1'b1};
            4'd5:    s = '{OFS_ZERO, OFS_DEC,  1'b0};
            4'd6:    s = '{OFS_INC,  OFS_ZERO, 1'b0};
            4'd7:    s = '{OFS_DEC,  OFS_DEC,  1'b1};
            4'd8:    s = '{OFS_DEC,  OFS_DEC,  1'b0};
            4'd9:    s = '{OFS_DEC,  OFS_ZERO, 1'b0};
            default: s = '{OFS_ZERO, OFS_ZERO, 1'b0};
        endcase
        if (sub) begin
            s.dx = ofs_neg(s.dx);
            s.dy = ofs_neg(s.dy);
        end
        return s;
    endfunction

    // Cell that owns bond j: the vacancy's own cell for site A, the
    // neighbour's cell for site B.
    function automatic t_step bond_step(input logic [BSTEP_W-1:0] j, input logic sub);
        t_step s;
        s = '{OFS_ZERO, OFS_ZERO, 1'b0};
        if (sub) begin
            case (j)
                2'd1:    s = '{OFS_ZERO, OFS_INC, 1'b0};
                2'd2:    s = '{OFS_INC,  OFS_INC, 1'b0};
                default: s = '{OFS_ZERO, OFS_ZERO, 1'b0};
            endcase
        end
        return s;
    endfunction

endpackage

// ----- design/hvp_cfg_if.sv -----
// Configuration write channel of the honeycomb vacancy placer.
interface hvp_cfg_if import hvp_pkg::*; ();
    logic             valid;
    logic             ready;
    t_cfg_reg         index;
    logic [CFG_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/hvp_in_if.sv -----
// Request channel of the honeycomb vacancy placer.
interface hvp_in_if import hvp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                mode;
    logic [CRD_IN_W-1:0] cell_x;
    logic [CRD_IN_W-1:0] cell_y;
    logic                sublattice;

    modport source (output valid, output mode, output cell_x, output cell_y,
                    output sublattice, input ready);
    modport sink   (input valid, input mode, input cell_x, input cell_y,
                    input sublattice, output ready);
endinterface

// ----- design/hvp_out_if.sv -----
// Result channel of the honeycomb vacancy placer.
interface hvp_out_if import hvp_pkg::*; ();
    logic              valid;
    logic              ready;
    t_status           status;
    logic [BOND_W-1:0] bond_index;
    logic              last;

    modport source (output valid, output status, output bond_index, output last,
                    input ready);
    modport sink   (input valid, input status, input bond_index, input last,
                    output ready);
endinterface

// ----- design/honeycomb_vacancy_placer_core.sv -----
// Top level of the honeycomb vacancy placer: site mark memory and placement sequencer.
//
//  channel  | direction | transaction
//  ---------+-----------+-----------------------------------------------
//  i_cfg    | in        | index, data: write cells_across or cells_down
//  i_in     | in        | mode, cell_x, cell_y, sublattice: one request
//  o_out    | out       | status, bond_index, last: one result
//
// A placement runs the size and range check, reads the vacancy's mark, then writes it
// and nine more marks, and gives one result per bond. All products come from the one
// row-times-width unit and all mark accesses use the single-port mark memory.
// A reject ends after the range check or after the mark read. A clear command and
// reset both sweep the whole memory with i_in.ready low; configuration writes are
// taken at any time. Output stalls hold the sequencer in place.
module honeycomb_vacancy_placer_core import hvp_pkg::*; #(
    parameter int MAX_SIDE  = 64,
    parameter int MAX_SITES = 8192
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hvp_cfg_if.sink    i_cfg,
    hvp_in_if.sink     i_in,
    hvp_out_if.source  o_out
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CRD_W  = (SIDE_W > CRD_IN_W) ? SIDE_W : CRD_IN_W;
    localparam int CLMP_W = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
    localparam int PROD_W = CRD_W + SIDE_W + 1;
    localparam int ADDR_W = $clog2(MAX_SITES);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MAX_SITES - 1);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_SIZE  = 10'b0000000100,
        ST_RANGE = 10'b0000001000,
        ST_ADDR  = 10'b0000010000,
        ST_READ  = 10'b0000100000,
        ST_CHECK = 10'b0001000000,
        ST_EXCL  = 10'b0010000000,
        ST_BOND  = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } t_state;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [CLMP_W-1:0] w;
        logic [SIDE_W-1:0] r;
        w = CLMP_W'(v);
        if (w < CLMP_W'(2)) begin
            r = SIDE_W'(2);
        end else if (w > CLMP_W'(MAX_SIDE)) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = SIDE_W'(w);
        end
        return r;
    endfunction

    function automatic logic [CRD_W-1:0] wrap(input logic [CRD_W-1:0] v, input t_ofs o,
                                              input logic [CRD_W-1:0] side);
        logic [CRD_W-1:0] r;
        case (o)
            OFS_INC: r = (v == side - 1'b1) ? '0 : v + 1'b1;
            OFS_DEC: r = (v == '0) ? side - 1'b1 : v - 1'b1;
            default: r = v;
        endcase
        return r;
    endfunction

    t_state               r_state, n_state;
    logic [SIDE_W-1:0]    r_ca, r_cd;
    logic [CRD_W-1:0]     r_x, r_y;
    logic                 r_sub;
    logic [STEP_W-1:0]    r_k, n_k;
    logic [BSTEP_W-1:0]   r_j, n_j;
    logic [ADDR_W-1:0]    r_clr, n_clr;
    logic                 r_report, n_report;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_site_sub;
    logic [MARK_W-1:0]    r_marks [MAX_SITES];
    logic [MARK_W-1:0]    r_rdata;
    t_status              r_status, n_status;
    logic [BOND_W-1:0]    r_bond, n_bond;
    logic                 r_last, n_last;

    // Shared unit controls.
    logic                 u_en, u_size, u_bond;
    logic [STEP_W-1:0]    u_k;
    logic [BSTEP_W-1:0]   u_j;
    t_step                u_step;
    logic [CRD_W-1:0]     u_a, u_b;
    logic [PROD_W-1:0]    u_prod;

    logic                 mem_we, mem_re, mem_sel_clr;
    logic [MARK_W-1:0]    mem_wdata;
    logic [ADDR_W-1:0]    mem_addr;
    logic                 reject;
    logic [PROD_W+1:0]    bond_sum;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);

    assign o_out.valid      = (r_state == ST_OUT);
    assign o_out.status     = r_status;
    assign o_out.bond_index = r_bond;
    assign o_out.last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ca <= clamp_side(SIDE_RST);
            r_cd <= clamp_side(SIDE_RST);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_CELLS_ACROSS: r_ca <= clamp_side(i_cfg.data);
                REG_CELLS_DOWN:   r_cd <= clamp_side(i_cfg.data);
                default: ;
            endcase
        end
    end

    // Row times width plus column: a cell number, or the lattice size.
    always_comb begin
        u_step = u_bond ? bond_step(u_j, r_sub) : site_step(u_k, r_sub);
        if (u_size) begin
            u_a = CRD_W'(r_cd);
            u_b = '0;
        end else begin
            u_a = wrap(r_y, u_step.dy, CRD_W'(r_cd));
            u_b = wrap(r_x, u_step.dx, CRD_W'(r_ca));
        end
        u_prod = PROD_W'(u_a) * PROD_W'(r_ca) + PROD_W'(u_b);
    end

    assign reject = (r_x >= CRD_W'(r_ca)) || (r_y >= CRD_W'(r_cd)) ||
                    (32'({r_prod, 1'b0}) > 32'(MAX_SITES));
    assign bond_sum = {2'b00, r_prod} + {1'b0, r_prod, 1'b0} + (PROD_W+2)'(r_j);
    assign mem_addr = mem_sel_clr ? r_clr : {(ADDR_W-1)'(r_prod), r_site_sub};

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_j         = r_j;
        n_clr       = r_clr;
        n_report    = r_report;
        n_status    = r_status;
        n_bond      = r_bond;
        n_last      = r_last;
        u_en        = 1'b0;
        u_size      = 1'b0;
        u_bond      = 1'b0;
        u_k         = '0;
        u_j         = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_sel_clr = 1'b0;
        mem_wdata   = MARK_FREE;
        case (r_state)
            ST_CLEAR: begin
                mem_sel_clr = 1'b1;
                mem_we      = 1'b1;
                n_clr       = r_clr + 1'b1;
                if (r_clr == ADDR_LAST) begin
                    n_clr    = '0;
                    n_report = 1'b0;
                    if (r_report) begin
                        n_status = STATUS_CLEARED;
                        n_bond   = '0;
                        n_last   = 1'b1;
                        n_state  = ST_OUT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.mode) begin
                        n_report = 1'b1;
                        n_state  = ST_CLEAR;
                    end else begin
                        n_state = ST_SIZE;
                    end
                end
            end
            ST_SIZE: begin
                u_en    = 1'b1;
                u_size  = 1'b1;
                n_state = ST_RANGE;
            end
            ST_RANGE: begin
                if (reject) begin
                    n_status = STATUS_RANGE;
                    n_bond   = '0;
                    n_last   = 1'b1;
                    n_state  = ST_OUT;
                end else begin
                    n_k     = '0;
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                u_en    = 1'b1;
                u_k     = r_k;
                n_state = ST_READ;
            end
            ST_READ: begin
                mem_re  = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_rdata != MARK_FREE) begin
                    n_status = STATUS_TAKEN;
                    n_bond   = '0;
                    n_last   = 1'b1;
                    n_state  = ST_OUT;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = MARK_VAC;
                    u_en      = 1'b1;
                    u_k       = STEP_W'(1);
                    n_k       = STEP_W'(1);
                    n_state   = ST_EXCL;
                end
            end
            ST_EXCL: begin
                // Write the current site while the unit forms the next address.
                mem_we    = 1'b1;
                mem_wdata = MARK_EXCL;
                u_en      = 1'b1;
                if (r_k == SITE_LAST) begin
                    u_bond  = 1'b1;
                    n_j     = '0;
                    n_state = ST_BOND;
                end else begin
                    u_k = r_k + 1'b1;
                    n_k = r_k + 1'b1;
                end
            end
            ST_BOND: begin
                n_status = STATUS_PLACED;
                n_bond   = BOND_W'(bond_sum);
                n_last   = (r_j == BOND_LAST);
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (o_out.ready) begin
                    if (r_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        u_en    = 1'b1;
                        u_bond  = 1'b1;
                        u_j     = r_j + 1'b1;
                        n_j     = r_j + 1'b1;
                        n_state = ST_BOND;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_report <= 1'b0;
            r_k      <= '0;
            r_j      <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_report <= n_report;
            r_k      <= n_k;
            r_j      <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_x   <= CRD_W'(i_in.cell_x);
            r_y   <= CRD_W'(i_in.cell_y);
            r_sub <= i_in.sublattice;
        end
        if (u_en) begin
            r_prod     <= u_prod;
            r_site_sub <= r_sub ^ u_step.flip;
        end
        r_status <= n_status;
        r_bond   <= n_bond;
        r_last   <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_marks[mem_addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_marks[mem_addr];
        end
    end

endmodule

// ----- design/hvp_checker.sv -----
// Port-level assertions for the honeycomb vacancy placer and their bind.
module hvp_checker import hvp_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input t_status           i_out_status,
    input logic [BOND_W-1:0] i_out_bond_index,
    input logic              i_out_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_status) &&
        $stable(i_out_bond_index) && $stable(i_out_last))
        else $error("result changed while stalled");

    // One request is in flight at a time.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !i_out_valid)
        else $error("request taken while a result is pending");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != STATUS_PLACED) |->
        i_out_last && (i_out_bond_index == '0))
        else $error("reject or clear result is not a single zero result");

    a_busy_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> !i_in_ready)
        else $error("request channel opened before the last bond result");

endmodule

bind honeycomb_vacancy_placer_core hvp_checker u_hvp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_status     (o_out.status),
    .i_out_bond_index (o_out.bond_index),
    .i_out_last       (o_out.last)
);

// ----- sim/honeycomb_vacancy_placer_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the honeycomb vacancy placer core.
module honeycomb_vacancy_placer_core_test;
    import hvp_pkg::*;

    localparam int SIDE_MAX      = 64;
    localparam int SITE_COUNT    = 8192;
    localparam int SETTLE_CYCLES = 40;
    // The slowest correct run is dominated by the clearing sweeps (some 20 of them at most)
    // plus about 200 requests when both sides stall as long as they can. The limit is
    // several times that.
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef struct {
        t_status           status;
        logic [BOND_W-1:0] bond_index;
        logic              last;
    } t_result;

    logic clk;
    logic rst_n;

    hvp_cfg_if cfg_bus ();
    hvp_in_if  req_bus ();
    hvp_out_if res_bus ();

    honeycomb_vacancy_placer_core #(
        .MAX_SIDE  (SIDE_MAX),
        .MAX_SITES (SITE_COUNT)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (req_bus),
        .o_out   (res_bus)
    );

    // Predicted lattice state.
    logic [MARK_W-1:0] site_mark [SITE_COUNT];
    int unsigned       width_cells;
    int unsigned       height_cells;
    t_result           awaited_results [$];

    int  fail_count    = 0;
    int  cycle_count   = 0;
    int  request_count = 0;
    int  placed_count  = 0;
    int  reject_count  = 0;
    int  clear_count   = 0;
    int  setting_count = 0;
    bit  no_idle       = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int unsigned clamp_side(logic [CFG_W-1:0] value);
        if (value < 2)
            return 2;
        if (value > SIDE_MAX)
            return SIDE_MAX;
        return 32'(value);
    endfunction

    // Site index of the neighbour of site s in direction dir, wrapped at the lattice edges.
    function automatic int unsigned adjacent_site(int unsigned s, int unsigned dir);
        int unsigned cell_no, x, y, nx, ny;
        cell_no = s >> 1;
        x       = cell_no % width_cells;
        y       = cell_no / width_cells;
        nx      = x;
        ny      = y;
        if ((s & 1) == 0) begin
            if (dir >= 1)
                ny = (y + height_cells - 1) % height_cells;
            if (dir == 2)
                nx = (x + width_cells - 1) % width_cells;
            return 2 * (nx + ny * width_cells) + 1;
        end
        if (dir >= 1)
            ny = (y + 1) % height_cells;
        if (dir == 2)
            nx = (x + 1) % width_cells;
        return 2 * (nx + ny * width_cells);
    endfunction

    function automatic void set_mark(int unsigned s, logic [MARK_W-1:0] value);
        if (s < SITE_COUNT)
            site_mark[s] = value;
    endfunction

    // Updates the lattice for one accepted request and queues the results it must cause.
    function automatic void compute_placement_results(logic mode, logic [CRD_IN_W-1:0] cx,
                                                      logic [CRD_IN_W-1:0] cy, logic sub);
        int unsigned s, n, base, bond;
        t_result     r;
        request_count++;
        r.bond_index = '0;
        r.last       = 1'b1;
        if (mode) begin
            foreach (site_mark[i])
                site_mark[i] = MARK_FREE;
            r.status = STATUS_CLEARED;
            awaited_results.push_back(r);
            clear_count++;
            return;
        end
        if (cx >= width_cells || cy >= height_cells
                || 2 * width_cells * height_cells > SITE_COUNT) begin
            r.status = STATUS_RANGE;
            awaited_results.push_back(r);
            reject_count++;
            return;
        end
        s = 2 * (cx + cy * width_cells) + sub;
        if (site_mark[s] != MARK_FREE) begin
            r.status = STATUS_TAKEN;
            awaited_results.push_back(r);
            reject_count++;
            return;
        end
        set_mark(s, MARK_VAC);
        for (int d = 0; d < 3; d++) begin
            n = adjacent_site(s, d);
            set_mark(n, MARK_EXCL);
            for (int e = 0; e < 3; e++)
                if (e != d)
                    set_mark(adjacent_site(n, e), MARK_EXCL);
        end
        for (int d = 0; d < 3; d++) begin
            base         = sub ? adjacent_site(s, d) : s;
            bond         = 3 * (base >> 1) + d;
            r.status     = STATUS_PLACED;
            r.bond_index = BOND_W'(bond);
            r.last       = (d == 2);
            awaited_results.push_back(r);
        end
        placed_count++;
    endfunction

    // Valid is left high after a transaction so that back-to-back requests need no gap.
    task automatic send_request(logic mode, logic [CRD_IN_W-1:0] cx,
                                logic [CRD_IN_W-1:0] cy, logic sub);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.mode       <= mode;
        req_bus.cell_x     <= cx;
        req_bus.cell_y     <= cy;
        req_bus.sublattice <= sub;
        do @(posedge clk); while (req_bus.ready !== 1'b1);
        compute_placement_results(mode, cx, cy, sub);
    endtask

    task automatic wait_for_drain();
        req_bus.valid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
    endtask

    task automatic write_side(t_cfg_reg idx, logic [CFG_W-1:0] value);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
        cfg_bus.valid <= 1'b0;
        if (idx == REG_CELLS_ACROSS)
            width_cells = clamp_side(value);
        else
            height_cells = clamp_side(value);
    endtask

    task automatic set_lattice(logic [CFG_W-1:0] across, logic [CFG_W-1:0] down);
        write_side(REG_CELLS_ACROSS, across);
        write_side(REG_CELLS_DOWN, down);
        setting_count++;
    endtask

    // Result sink: stalls at random and checks every transaction against the oldest prediction.
    initial begin : result_sink
        t_result want;
        int      stall;
        res_bus.ready <= 1'b0;
        @(posedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge clk); while (!(rst_n === 1'b1 && res_bus.valid === 1'b1));
            if (awaited_results.size() == 0) begin
                $error("unexpected result: status %0d, bond_index %0d, last %0d",
                       res_bus.status, res_bus.bond_index, res_bus.last);
                fail_count++;
            end else begin
                want = awaited_results.pop_front();
                if (res_bus.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_bus.status);
                    fail_count++;
                end
                if (res_bus.bond_index !== want.bond_index) begin
                    $error("bond_index: expected %0d, got %0d",
                           want.bond_index, res_bus.bond_index);
                    fail_count++;
                end
                if (res_bus.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, res_bus.last);
                    fail_count++;
                end
            end
        end
    end

    // Full-size lattice: wrapping on both edges, a repeated site and excluded sites.
    task automatic test_placement_wrap();
        send_request(1'b0, 6'd0, 6'd0, 1'b0);
        send_request(1'b0, 6'd0, 6'd0, 1'b0);
        send_request(1'b0, 6'd63, 6'd63, 1'b1);
        send_request(1'b0, 6'd63, 6'd0, 1'b0);
        send_request(1'b0, 6'd63, 6'd40, 1'b1);
        send_request(1'b0, 6'd10, 6'd63, 1'b1);
        send_request(1'b0, 6'd31, 6'd45, 1'b0);
    endtask

    task automatic test_coordinate_range();
        set_lattice(7'd5, 7'd3);
        send_request(1'b0, 6'd5, 6'd0, 1'b0);
        send_request(1'b0, 6'd0, 6'd3, 1'b1);
        send_request(1'b0, 6'd63, 6'd63, 1'b1);
        send_request(1'b0, 6'd4, 6'd2, 1'b1);
        send_request(1'b0, 6'd0, 6'd0, 1'b0);
    endtask

    // Side values below and above the legal range saturate; clears ignore the other fields.
    task automatic test_side_saturation();
        set_lattice(7'd0, 7'd1);
        send_request(1'b0, 6'd1, 6'd1, 1'b0);
        send_request(1'b0, 6'd1, 6'd1, 1'b1);
        send_request(1'b0, 6'd0, 6'd0, 1'b0);
        send_request(1'b1, 6'd63, 6'd63, 1'b1);
        send_request(1'b0, 6'd1, 6'd1, 1'b0);
        set_lattice(7'd127, 7'd127);
        send_request(1'b1, 6'd0, 6'd0, 1'b0);
        send_request(1'b0, 6'd63, 6'd0, 1'b1);
    endtask

    task automatic test_random_phases();
        logic [CFG_W-1:0] across_list [6];
        logic [CFG_W-1:0] down_list [6];
        int               pick;
        int               clear_pct;
        across_list = '{7'd64, 7'd2, 7'd3, 7'd64, 7'd2, 7'd0};
        down_list   = '{7'd64, 7'd2, 7'd7, 7'd2, 7'd64, 7'd0};
        across_list[5] = CFG_W'($urandom_range(0, 127));
        down_list[5]   = CFG_W'($urandom_range(0, 127));
        for (int p = 0; p < 6; p++) begin
            set_lattice(across_list[p], down_list[p]);
            if ($urandom_range(0, 2) == 0)
                send_request(1'b1, CRD_IN_W'($urandom), CRD_IN_W'($urandom), 1'($urandom));
            // Small lattices fill up after a few placements, so they are cleared more often.
            clear_pct = (width_cells * height_cells <= 32) ? 12 : 3;
            for (int k = 0; k < 25; k++) begin
                if (k % 8 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (pick < clear_pct)
                    send_request(1'b1, CRD_IN_W'($urandom), CRD_IN_W'($urandom),
                                 1'($urandom));
                else if (pick < clear_pct + 10)
                    send_request(1'b0, CRD_IN_W'($urandom_range(0, 63)),
                                 CRD_IN_W'($urandom_range(0, 63)),
                                 1'($urandom_range(0, 1)));
                else
                    send_request(1'b0, CRD_IN_W'($urandom_range(0, width_cells - 1)),
                                 CRD_IN_W'($urandom_range(0, height_cells - 1)),
                                 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 19) == 0)
                    wait_for_drain();
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        rst_n              <= 1'b0;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= REG_CELLS_ACROSS;
        cfg_bus.data       <= '0;
        req_bus.valid      <= 1'b0;
        req_bus.mode       <= 1'b0;
        req_bus.cell_x     <= '0;
        req_bus.cell_y     <= '0;
        req_bus.sublattice <= 1'b0;
        width_cells  = SIDE_MAX;
        height_cells = SIDE_MAX;
        foreach (site_mark[i])
            site_mark[i] = MARK_FREE;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_placement_wrap();
        test_coordinate_range();
        test_side_saturation();
        test_random_phases();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d requests: %0d placements, %0d rejects, %0d clears,",
                 request_count, placed_count, reject_count, clear_count);
        $display("over %0d lattice sizes in %0d cycles.", setting_count + 1, cycle_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
design/hvp_pkg.sv
design/hvp_cfg_if.sv
design/hvp_in_if.sv
design/hvp_out_if.sv
design/honeycomb_vacancy_placer_core.sv
design/hvp_checker.sv
sim/honeycomb_vacancy_placer_core_test.sv
